>>> src/ssp_pkg.sv
package ssp_pkg;

  localparam int SelBytes = 16;
  localparam int PosBits = 16;
  localparam int SelCntBits = $clog2(SelBytes + 1);
  localparam int SelIdxBits = $clog2(SelBytes);

  typedef enum logic [3:0] {
    PH_CODE  = 4'd0,
    PH_LEN   = 4'd1,
    PH_DATA2 = 4'd2,
    PH_DATA3 = 4'd3,
    PH_IDLE  = 4'd4,
    PH_PGI   = 4'd5,
    PH_PLEN  = 4'd6,
    PH_SKIP  = 4'd7,
    PH_API   = 4'd8,
    PH_APLEN = 4'd9,
    PH_AOPT  = 4'd10,
    PH_AVER  = 4'd11,
    PH_ASKIP = 4'd12,
    PH_REQ   = 4'd13,
    PH_SEL   = 4'd14
  } phase_t;

  // SPDU codes.
  localparam logic [7:0] SPDU_DATA       = 8'd1;
  localparam logic [7:0] SPDU_NOT_FIN    = 8'd8;
  localparam logic [7:0] SPDU_FINISH     = 8'd9;
  localparam logic [7:0] SPDU_DISCONNECT = 8'd10;
  localparam logic [7:0] SPDU_CONNECT    = 8'd13;
  localparam logic [7:0] SPDU_ACCEPT     = 8'd14;
  localparam logic [7:0] SPDU_ABORT      = 8'd25;

  // Parameter identifiers.
  localparam logic [7:0] PI_ACCEPT    = 8'd5;
  localparam logic [7:0] PI_OPTIONS   = 8'd19;
  localparam logic [7:0] PI_REQUIRE   = 8'd20;
  localparam logic [7:0] PI_TSDU      = 8'd21;
  localparam logic [7:0] PI_VERSION   = 8'd22;
  localparam logic [7:0] PI_ISN       = 8'd26;
  localparam logic [7:0] PI_CALLING   = 8'd51;
  localparam logic [7:0] PI_CALLED    = 8'd52;
  localparam logic [7:0] PGI_USERDATA = 8'd193;

  // Indications.
  localparam logic [2:0] IND_ERROR   = 3'd0;
  localparam logic [2:0] IND_CONNECT = 3'd1;
  localparam logic [2:0] IND_DATA    = 3'd2;
  localparam logic [2:0] IND_NOT_FIN = 3'd3;
  localparam logic [2:0] IND_FINISH  = 3'd4;
  localparam logic [2:0] IND_DISC    = 3'd5;
  localparam logic [2:0] IND_ABORT   = 3'd6;

  typedef logic [SelBytes-1:0][7:0] sel_t;

  typedef struct packed {
    logic [7:0]            options;
    logic [15:0]           requirement;
    sel_t                  calling;
    sel_t                  called;
    logic [SelCntBits-1:0] calling_n;
    logic [SelCntBits-1:0] called_n;
  } store_t;

  function automatic store_t store_init();
    store_t s;
    s = '0;
    s.requirement = 16'h0002;
    s.calling[1] = 8'd1;
    s.called[1] = 8'd1;
    s.calling_n = SelCntBits'(2);
    s.called_n = SelCntBits'(2);
    return s;
  endfunction

  function automatic logic is_header(input logic [7:0] c);
    return c == SPDU_CONNECT || c == SPDU_ACCEPT || c == SPDU_FINISH ||
           c == SPDU_DISCONNECT;
  endfunction

  function automatic logic [2:0] header_ind(input logic [7:0] c);
    if (c == SPDU_FINISH) return IND_FINISH;
    if (c == SPDU_DISCONNECT) return IND_DISC;
    return IND_CONNECT;
  endfunction

  // Eight selector bytes from first on, bytes at or past count read as zero.
  function automatic logic [63:0] sel_pack(input sel_t b, input logic [SelCntBits-1:0] n,
                                           input int first);
    logic [63:0] v;
    v = '0;
    for (int k = 0; k < 8; k++) begin
      if (first + k < SelBytes && (first + k) < int'(n))
        v[8*k +: 8] = b[(first + k) % SelBytes];
    end
    return v;
  endfunction

endpackage

>>> src/ssp_if.sv
interface ssp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;
  modport source (output valid, byte_value, last_byte, input ready);
  modport sink (input valid, byte_value, last_byte, output ready);
endinterface

interface ssp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  indication;
  logic [8:0]  user_data_offset;
  logic [7:0]  protocol_options;
  logic [15:0] session_requirement;
  logic [4:0]  calling_length;
  logic [4:0]  called_length;
  logic [63:0] calling_low;
  logic [63:0] calling_high;
  logic [63:0] called_low;
  logic [63:0] called_high;
  modport source (output valid, indication, user_data_offset, protocol_options,
                  session_requirement, calling_length, called_length, calling_low,
                  calling_high, called_low, called_high, input ready);
  modport sink (input valid, indication, user_data_offset, protocol_options,
                session_requirement, calling_length, called_length, calling_low,
                calling_high, called_low, called_high, output ready);
endinterface

>>> src/session_spdu_parser.sv
// Channel | Direction | Fields
// in_     | sink      | byte_value[7:0], last_byte
// out_    | source    | indication, user_data_offset, options, requirement, selectors
//
// One byte per cycle is taken while ready is high, and parsed in the cycle it is accepted.
// The result of a last byte appears in the output register on the next cycle.
// The one-entry output register is the only buffer, so input ready is low only
// while that register is full and the result side is not taking it.
// Reset (rst_n low, synchronous) restores the default stores and clears the parse.
module session_spdu_parser (
  input logic clk,
  input logic rst_n,
  ssp_in_if.sink    in_ch,
  ssp_out_if.source out_ch
);
  import ssp_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [PosBits-1:0] pos_r, pos_nxt;
  logic [7:0]         code_r, code_nxt;
  logic [7:0]         dlen_r, dlen_nxt;
  logic [7:0]         rem_r, rem_nxt;
  logic [8:0]         aend_r, aend_nxt;
  logic [1:0]         aflags_r, aflags_nxt;
  logic [2:0]         verdict_r, verdict_nxt;
  logic [8:0]         dstart_r, dstart_nxt;
  logic [7:0]         id_r, id_nxt;
  store_t             com_r, com_nxt;
  store_t             work_r, work_nxt;

  logic        ovalid_r;
  logic [2:0]  oind_r;
  logic [8:0]  ooff_r;
  logic        acc;
  logic [2:0]  ind;
  logic [8:0]  off;
  logic [8:0]  pos9;
  logic [SelCntBits:0] sidx;
  logic [PosBits:0] size;

  assign in_ch.ready = !ovalid_r || out_ch.ready;
  assign acc = in_ch.valid && in_ch.ready;
  assign pos9 = pos_r[8:0];
  assign size = {1'b0, pos_r} + 1'b1;

  always_comb begin
    logic [7:0] b;
    logic [8:0] p1;
    b = in_ch.byte_value;
    p1 = pos9 + 9'd1;
    phase_nxt = phase_r; pos_nxt = pos_r; code_nxt = code_r; dlen_nxt = dlen_r;
    rem_nxt = rem_r; aend_nxt = aend_r; aflags_nxt = aflags_r; verdict_nxt = verdict_r;
    dstart_nxt = dstart_r; id_nxt = id_r; com_nxt = com_r; work_nxt = work_r;
    ind = verdict_r;
    off = '0;
    sidx = '0;
    if (acc) begin
      case (phase_r)
        PH_CODE: begin
          code_nxt = b; verdict_nxt = IND_ERROR; work_nxt = com_r; phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          dlen_nxt = b;
          if (is_header(code_r)) phase_nxt = PH_PGI;
          else if (code_r == SPDU_DATA) phase_nxt = (b == 8'd0) ? PH_DATA2 : PH_IDLE;
          else begin
            if (code_r == SPDU_NOT_FIN) verdict_nxt = IND_NOT_FIN;
            else if (code_r == SPDU_ABORT) verdict_nxt = IND_ABORT;
            phase_nxt = PH_IDLE;
          end
        end
        PH_DATA2: phase_nxt = (b == 8'd1) ? PH_DATA3 : PH_IDLE;
        PH_DATA3: begin
          if (b == 8'd0) begin
            verdict_nxt = IND_DATA; dstart_nxt = 9'd4;
          end
          phase_nxt = PH_IDLE;
        end
        PH_PGI: begin id_nxt = b; phase_nxt = PH_PLEN; end
        PH_API: begin id_nxt = b; phase_nxt = PH_APLEN; end
        PH_PLEN: begin
          case (id_r)
            8'd1, 8'd17, 8'd25, 8'd49, 8'd60: begin
              rem_nxt = b; phase_nxt = (b == 8'd0) ? PH_PGI : PH_SKIP;
            end
            PI_ACCEPT: begin
              aend_nxt = p1 + {1'b0, b}; aflags_nxt = 2'd0;
              phase_nxt = (b == 8'd0) ? PH_IDLE : PH_API;
              if (b == 8'd0) verdict_nxt = IND_ERROR;
            end
            PI_REQUIRE: begin
              if (b != 8'd2) begin verdict_nxt = IND_ERROR; phase_nxt = PH_IDLE; end
              else begin rem_nxt = 8'd2; phase_nxt = PH_REQ; end
            end
            PI_CALLING, PI_CALLED: begin
              if (b > 8'(SelBytes)) begin
                verdict_nxt = IND_ERROR; phase_nxt = PH_IDLE;
              end else begin
                if (id_r == PI_CALLING) work_nxt.calling_n = SelCntBits'(b);
                else work_nxt.called_n = SelCntBits'(b);
                rem_nxt = b; phase_nxt = (b == 8'd0) ? PH_PGI : PH_SEL;
              end
            end
            PGI_USERDATA: begin
              dstart_nxt = p1; verdict_nxt = header_ind(code_r); phase_nxt = PH_IDLE;
            end
            default: phase_nxt = PH_PGI;
          endcase
        end
        PH_SKIP: begin
          rem_nxt = rem_r - 8'd1;
          if (rem_r == 8'd1) phase_nxt = PH_PGI;
        end
        PH_APLEN: begin
          case (id_r)
            PI_OPTIONS: begin
              if (b != 8'd1) begin verdict_nxt = IND_ERROR; phase_nxt = PH_IDLE; end
              else phase_nxt = PH_AOPT;
            end
            PI_TSDU: begin rem_nxt = 8'd4; phase_nxt = PH_ASKIP; end
            PI_VERSION: phase_nxt = PH_AVER;
            8'd23, 8'd55, 8'd56, 8'd57, 8'd58: begin
              rem_nxt = b;
              if (b != 8'd0) phase_nxt = PH_ASKIP;
              else if (p1 < aend_r) phase_nxt = PH_API;
              else if (aflags_r == 2'd3) phase_nxt = PH_PGI;
              else begin verdict_nxt = IND_ERROR; phase_nxt = PH_IDLE; end
            end
            PI_ISN: begin rem_nxt = 8'd1; phase_nxt = PH_ASKIP; end
            default: begin
              if (p1 < aend_r) phase_nxt = PH_API;
              else if (aflags_r == 2'd3) phase_nxt = PH_PGI;
              else begin verdict_nxt = IND_ERROR; phase_nxt = PH_IDLE; end
            end
          endcase
        end
        PH_AOPT: begin
          work_nxt.options = b;
          aflags_nxt = aflags_r | 2'd1;
          if (p1 < aend_r) phase_nxt = PH_API;
          else if ((aflags_r | 2'd1) == 2'd3) phase_nxt = PH_PGI;
          else begin verdict_nxt = IND_ERROR; phase_nxt = PH_IDLE; end
        end
        PH_AVER: begin
          if (b != 8'd2) begin verdict_nxt = IND_ERROR; phase_nxt = PH_IDLE; end
          else begin
            aflags_nxt = aflags_r | 2'd2;
            if (p1 < aend_r) phase_nxt = PH_API;
            else if ((aflags_r | 2'd2) == 2'd3) phase_nxt = PH_PGI;
            else begin verdict_nxt = IND_ERROR; phase_nxt = PH_IDLE; end
          end
        end
        PH_ASKIP: begin
          rem_nxt = rem_r - 8'd1;
          if (rem_r == 8'd1) begin
            if (p1 < aend_r) phase_nxt = PH_API;
            else if (aflags_r == 2'd3) phase_nxt = PH_PGI;
            else begin verdict_nxt = IND_ERROR; phase_nxt = PH_IDLE; end
          end
        end
        PH_REQ: begin
          if (rem_r == 8'd2) work_nxt.requirement = {b, 8'd0};
          else work_nxt.requirement = {work_r.requirement[15:8], b};
          rem_nxt = rem_r - 8'd1;
          if (rem_r == 8'd1) phase_nxt = PH_PGI;
        end
        PH_SEL: begin
          if (id_r == PI_CALLING) begin
            sidx = {1'b0, work_r.calling_n} - (SelCntBits+1)'(rem_r);
            if (sidx < (SelCntBits+1)'(SelBytes))
              work_nxt.calling[sidx[SelIdxBits-1:0]] = b;
          end else begin
            sidx = {1'b0, work_r.called_n} - (SelCntBits+1)'(rem_r);
            if (sidx < (SelCntBits+1)'(SelBytes))
              work_nxt.called[sidx[SelIdxBits-1:0]] = b;
          end
          rem_nxt = rem_r - 8'd1;
          if (rem_r == 8'd1) phase_nxt = PH_PGI;
        end
        default: ;
      endcase
      if (pos_r != '1) pos_nxt = pos_r + 1'b1;

      // Last byte: judge the message, commit the stores of a well-formed header, restart.
      if (in_ch.last_byte) begin
        ind = verdict_nxt;
        off = dstart_nxt;
        if (size < 2) ind = IND_ERROR;
        else if (is_header(code_nxt)) begin
          if ({{(PosBits-7){1'b0}}, dlen_nxt} + 2 == size) com_nxt = work_nxt;
          else ind = IND_ERROR;
        end
        pos_nxt = '0; code_nxt = '0; dlen_nxt = '0; phase_nxt = PH_CODE; rem_nxt = '0;
        aend_nxt = '0; aflags_nxt = '0; verdict_nxt = '0; dstart_nxt = '0; id_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CODE; pos_r <= '0; code_r <= '0; dlen_r <= '0; rem_r <= '0;
      aend_r <= '0; aflags_r <= '0; verdict_r <= '0; dstart_r <= '0; id_r <= '0;
      com_r <= store_init(); work_r <= store_init(); ovalid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; code_r <= code_nxt; dlen_r <= dlen_nxt;
      rem_r <= rem_nxt; aend_r <= aend_nxt; aflags_r <= aflags_nxt;
      verdict_r <= verdict_nxt; dstart_r <= dstart_nxt; id_r <= id_nxt;
      com_r <= com_nxt; work_r <= work_nxt;
      if (acc && in_ch.last_byte) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  // Result payload; the stores are read from the committed copy.
  always_ff @(posedge clk) begin
    if (acc && in_ch.last_byte) begin
      oind_r <= ind;
      ooff_r <= (ind == IND_CONNECT || ind == IND_DATA || ind == IND_FINISH ||
                 ind == IND_DISC) ? off : 9'd0;
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.indication = oind_r;
  assign out_ch.user_data_offset = ooff_r;
  assign out_ch.protocol_options = com_r.options;
  assign out_ch.session_requirement = com_r.requirement;
  assign out_ch.calling_length = 5'(com_r.calling_n);
  assign out_ch.called_length = 5'(com_r.called_n);
  assign out_ch.calling_low = sel_pack(com_r.calling, com_r.calling_n, 0);
  assign out_ch.calling_high = sel_pack(com_r.calling, com_r.calling_n, 8);
  assign out_ch.called_low = sel_pack(com_r.called, com_r.called_n, 0);
  assign out_ch.called_high = sel_pack(com_r.called, com_r.called_n, 8);

  // Selector counts never exceed the store size.
  a_sel_n: assert property (@(posedge clk) disable iff (!rst_n)
    com_r.calling_n <= SelCntBits'(SelBytes) && com_r.called_n <= SelCntBits'(SelBytes))
    else $error("selector count out of range");

  // A last byte always restarts the parse at the code byte.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.last_byte |=> phase_r == PH_CODE && pos_r == '0)
    else $error("parse not restarted");

  // An error indication never carries an offset.
  a_off: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && oind_r == IND_ERROR |-> ooff_r == 9'd0)
    else $error("offset on error");
endmodule

>>> test/session_spdu_parser_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts the parser's result for each message and
// compares every accepted result with the oldest prediction.
module session_spdu_parser_checker (
  input  logic  clk,
  input  logic  rst_n,
  ssp_in_if     in_mon,
  ssp_out_if    out_mon,
  output int    errors,
  output int    pending
);
  import ssp_pkg::*;

  typedef struct {
    logic [7:0]  options;
    logic [15:0] requirement;
    logic [7:0]  calling[SelBytes];
    logic [7:0]  called[SelBytes];
    int          calling_n;
    int          called_n;
  } sel_store_t;

  typedef struct {
    logic [2:0]  indication;
    logic [8:0]  offset;
    logic [7:0]  options;
    logic [15:0] requirement;
    logic [4:0]  calling_len;
    logic [4:0]  called_len;
    logic [63:0] calling_lo;
    logic [63:0] calling_hi;
    logic [63:0] called_lo;
    logic [63:0] called_hi;
  } indication_t;

  indication_t indication_q[$];

  // Parse state of the message in progress.
  int          position;
  logic [7:0]  code;
  logic [7:0]  length_byte;
  phase_t      phase;
  int          remaining;
  int          accept_stop;
  logic [1:0]  accept_seen;
  logic [2:0]  verdict;
  int          user_start;
  logic [7:0]  param_id;
  sel_store_t  committed;
  sel_store_t  working;

  function automatic sel_store_t default_store();
    sel_store_t s;
    s.options = '0;
    s.requirement = 16'h0002;
    for (int i = 0; i < SelBytes; i++) begin
      s.calling[i] = '0;
      s.called[i] = '0;
    end
    s.calling[1] = 8'd1;
    s.called[1] = 8'd1;
    s.calling_n = 2;
    s.called_n = 2;
    return s;
  endfunction

  function automatic logic [63:0] gather(input logic [7:0] b[SelBytes], input int n,
                                         input int first);
    logic [63:0] v;
    v = '0;
    for (int k = 0; k < 8; k++) begin
      if (first + k < n && first + k < SelBytes) v[8*k +: 8] = b[first + k];
    end
    return v;
  endfunction

  function automatic logic is_session_header(input logic [7:0] c);
    return c == SPDU_CONNECT || c == SPDU_ACCEPT || c == SPDU_FINISH ||
           c == SPDU_DISCONNECT;
  endfunction

  function automatic void clear_message();
    position = 0;
    code = '0;
    length_byte = '0;
    phase = PH_CODE;
    remaining = 0;
    accept_stop = 0;
    accept_seen = '0;
    verdict = IND_ERROR;
    user_start = 0;
    param_id = '0;
  endfunction

  function automatic void abandon();
    verdict = IND_ERROR;
    phase = PH_IDLE;
  endfunction

  // Go on to the next sub-parameter, leave the accept item, or abandon the message.
  function automatic void accept_advance(input int pos);
    if (pos + 1 < accept_stop) phase = PH_API;
    else if (accept_seen == 2'b11) phase = PH_PGI;
    else abandon();
  endfunction

  function automatic void top_length(input logic [7:0] len, input int pos);
    case (param_id)
      8'd1, 8'd17, 8'd25, 8'd49, 8'd60: begin
        remaining = len;
        phase = (len == 0) ? PH_PGI : PH_SKIP;
      end
      PI_ACCEPT: begin
        accept_stop = pos + 1 + len;
        accept_seen = '0;
        if (len == 0) abandon();
        else phase = PH_API;
      end
      PI_REQUIRE: begin
        if (len != 2) abandon();
        else begin
          remaining = 2;
          phase = PH_REQ;
        end
      end
      PI_CALLING, PI_CALLED: begin
        if (len > SelBytes) abandon();
        else begin
          if (param_id == PI_CALLING) working.calling_n = len;
          else working.called_n = len;
          remaining = len;
          phase = (len == 0) ? PH_PGI : PH_SEL;
        end
      end
      PGI_USERDATA: begin
        user_start = pos + 1;
        verdict = (code == SPDU_FINISH) ? IND_FINISH :
                  (code == SPDU_DISCONNECT) ? IND_DISC : IND_CONNECT;
        phase = PH_IDLE;
      end
      default: phase = PH_PGI;
    endcase
  endfunction

  function automatic void accept_length(input logic [7:0] len, input int pos);
    case (param_id)
      PI_OPTIONS: begin
        if (len != 1) abandon();
        else phase = PH_AOPT;
      end
      PI_TSDU: begin
        remaining = 4;
        phase = PH_ASKIP;
      end
      PI_VERSION: phase = PH_AVER;
      8'd23, 8'd55, 8'd56, 8'd57, 8'd58: begin
        remaining = len;
        if (len == 0) accept_advance(pos);
        else phase = PH_ASKIP;
      end
      PI_ISN: begin
        remaining = 1;
        phase = PH_ASKIP;
      end
      default: accept_advance(pos);
    endcase
  endfunction

  // Advances the parse by one byte; returns 1 with a prediction on the last byte.
  function automatic logic parse_byte(input logic [7:0] b, input logic last,
                                      output indication_t r);
    int pos;
    int idx;
    logic [2:0] ind;
    pos = position;
    case (phase)
      PH_CODE: begin
        code = b;
        verdict = IND_ERROR;
        working = committed;
        phase = PH_LEN;
      end
      PH_LEN: begin
        length_byte = b;
        if (is_session_header(code)) phase = PH_PGI;
        else if (code == SPDU_DATA) phase = (b == 0) ? PH_DATA2 : PH_IDLE;
        else begin
          if (code == SPDU_NOT_FIN) verdict = IND_NOT_FIN;
          else if (code == SPDU_ABORT) verdict = IND_ABORT;
          phase = PH_IDLE;
        end
      end
      PH_DATA2: phase = (b == 1) ? PH_DATA3 : PH_IDLE;
      PH_DATA3: begin
        if (b == 0) begin
          verdict = IND_DATA;
          user_start = 4;
        end
        phase = PH_IDLE;
      end
      PH_PGI, PH_API: begin
        param_id = b;
        phase = (phase == PH_PGI) ? PH_PLEN : PH_APLEN;
      end
      PH_PLEN: top_length(b, pos);
      PH_SKIP: begin
        remaining--;
        if (remaining == 0) phase = PH_PGI;
      end
      PH_APLEN: accept_length(b, pos);
      PH_AOPT: begin
        working.options = b;
        accept_seen[0] = 1'b1;
        accept_advance(pos);
      end
      PH_AVER: begin
        if (b != 2) abandon();
        else begin
          accept_seen[1] = 1'b1;
          accept_advance(pos);
        end
      end
      PH_ASKIP: begin
        remaining--;
        if (remaining == 0) accept_advance(pos);
      end
      PH_REQ: begin
        if (remaining == 2) working.requirement = {b, 8'h00};
        else working.requirement[7:0] = b;
        remaining--;
        if (remaining == 0) phase = PH_PGI;
      end
      PH_SEL: begin
        if (param_id == PI_CALLING) begin
          idx = working.calling_n - remaining;
          if (idx < SelBytes) working.calling[idx] = b;
        end else begin
          idx = working.called_n - remaining;
          if (idx < SelBytes) working.called[idx] = b;
        end
        remaining--;
        if (remaining == 0) phase = PH_PGI;
      end
      default: ;
    endcase
    if (position < (1 << PosBits) - 1) position++;
    if (!last) return 1'b0;

    ind = verdict;
    if (pos + 1 < 2) ind = IND_ERROR;
    else if (is_session_header(code)) begin
      if (length_byte + 2 == pos + 1) committed = working;
      else ind = IND_ERROR;
    end
    r.indication = ind;
    r.offset = (ind == IND_CONNECT || ind == IND_DATA || ind == IND_FINISH ||
                ind == IND_DISC) ? user_start[8:0] : 9'd0;
    r.options = committed.options;
    r.requirement = committed.requirement;
    r.calling_len = committed.calling_n[4:0];
    r.called_len = committed.called_n[4:0];
    r.calling_lo = gather(committed.calling, committed.calling_n, 0);
    r.calling_hi = gather(committed.calling, committed.calling_n, 8);
    r.called_lo = gather(committed.called, committed.called_n, 0);
    r.called_hi = gather(committed.called, committed.called_n, 8);
    clear_message();
    return 1'b1;
  endfunction

  function automatic void compare(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
    end
  endfunction

  assign pending = indication_q.size();

  initial begin
    errors = 0;
    committed = default_store();
    working = default_store();
    clear_message();
  end

  // Check results first, then feed the accepted byte to the prediction.
  always @(posedge clk) begin
    indication_t want;
    indication_t got;
    if (!rst_n) begin
      indication_q.delete();
      committed = default_store();
      working = default_store();
      clear_message();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (indication_q.size() == 0) begin
          $error("result item with no prediction waiting");
          errors++;
        end else begin
          want = indication_q.pop_front();
          compare("indication", want.indication, out_mon.indication);
          compare("user_data_offset", want.offset, out_mon.user_data_offset);
          compare("protocol_options", want.options, out_mon.protocol_options);
          compare("session_requirement", want.requirement, out_mon.session_requirement);
          compare("calling_length", want.calling_len, out_mon.calling_length);
          compare("called_length", want.called_len, out_mon.called_length);
          compare("calling_low", want.calling_lo, out_mon.calling_low);
          compare("calling_high", want.calling_hi, out_mon.calling_high);
          compare("called_low", want.called_lo, out_mon.called_low);
          compare("called_high", want.called_hi, out_mon.called_high);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (parse_byte(in_mon.byte_value, in_mon.last_byte, got)) indication_q.push_back(got);
      end
    end
  end

endmodule

>>> test/session_spdu_parser_tb.sv
`timescale 1ns / 100ps

module session_spdu_parser_tb;
  import ssp_pkg::*;

  logic clk;
  logic rst_n;
  logic calm;
  int   errors;
  int   pending;
  int   bytes_sent;

  ssp_in_if  in_ch ();
  ssp_out_if out_ch ();

  session_spdu_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  session_spdu_parser_checker checker_i (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  typedef logic [7:0] octet_q_t[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("session_spdu_parser: mismatch");
    $finish;
  end

  // The result side stalls at random unless the quiet stretch is on.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  // Sends one item, with random idle cycles before it.
  task automatic send_octet(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.byte_value <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_message(input octet_q_t m);
    foreach (m[i]) send_octet(m[i], i == m.size() - 1);
  endtask

  function automatic octet_q_t rand_octets(input int n);
    octet_q_t q;
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  // Accept item body; flaws it now and then.
  function automatic octet_q_t accept_body();
    octet_q_t q;
    int n;
    if ($urandom_range(9) != 0) q = {PI_OPTIONS, 8'd1, 8'($urandom)};
    if ($urandom_range(9) != 0) q = {q, PI_VERSION, 8'd1, ($urandom_range(9) == 0) ? 8'd3 : 8'd2};
    if ($urandom_range(2) == 0) q = {q, PI_TSDU, 8'd4, rand_octets(4)};
    if ($urandom_range(2) == 0) q = {q, PI_ISN, 8'd1, 8'($urandom)};
    if ($urandom_range(2) == 0) begin
      n = $urandom_range(3);
      q = {q, 8'($urandom_range(55, 58)), 8'(n), rand_octets(n)};
    end
    if ($urandom_range(4) == 0) q.shuffle();
    return q;
  endfunction

  // CONNECT, ACCEPT, FINISH or DISCONNECT with a random parameter list.
  function automatic octet_q_t header_message(input logic [7:0] code);
    octet_q_t q;
    octet_q_t body;
    int n;
    q = {code, 8'd0};
    repeat ($urandom_range(4)) begin
      case ($urandom_range(6))
        0, 1: begin
          n = ($urandom_range(15) == 0) ? 17 : $urandom_range(16);
          q = {q, ($urandom_range(1) != 0) ? PI_CALLING : PI_CALLED, 8'(n), rand_octets(n)};
        end
        2: q = {q, PI_REQUIRE, ($urandom_range(9) == 0) ? 8'd3 : 8'd2, rand_octets(2)};
        3: begin
          body = accept_body();
          q = {q, PI_ACCEPT, 8'(body.size()), body};
        end
        4: begin
          n = $urandom_range(3);
          q = {q, ($urandom_range(1) != 0) ? 8'd17 : 8'd60, 8'(n), rand_octets(n)};
        end
        5: q = {q, 8'd99, 8'($urandom)};
        default: q = {q, 8'd1, 8'd0};
      endcase
    end
    if ($urandom_range(5) != 0) q = {q, PGI_USERDATA, 8'($urandom), rand_octets($urandom_range(6))};
    // Now and then cut the message short or give it a wrong length.
    case ($urandom_range(9))
      0: q = q[0:$urandom_range(q.size() - 1)];
      1: q[1] = 8'($urandom);
      default: ;
    endcase
    if (q.size() >= 2 && !($urandom_range(9) == 1)) q[1] = 8'(q.size() - 2);
    return q;
  endfunction

  function automatic octet_q_t random_message();
    octet_q_t q;
    case ($urandom_range(11))
      0: q = header_message(SPDU_CONNECT);
      1, 2: q = header_message(SPDU_ACCEPT);
      3: q = header_message(SPDU_FINISH);
      4: q = header_message(SPDU_DISCONNECT);
      5: q = ($urandom_range(3) == 0) ? rand_octets($urandom_range(1, 6))
                                       : {SPDU_DATA, 8'd0, 8'd1, 8'd0, rand_octets($urandom_range(4))};
      6: q = {SPDU_NOT_FIN, rand_octets($urandom_range(1, 3))};
      7: q = {SPDU_ABORT, rand_octets($urandom_range(1, 3))};
      8: q = rand_octets($urandom_range(1, 8));
      default: q = header_message(8'($urandom_range(1) != 0 ? SPDU_CONNECT : SPDU_ACCEPT));
    endcase
    return q;
  endfunction

  initial begin
    int msgs;
    calm = 1'b0;
    bytes_sent = 0;
    in_ch.valid = 1'b0;
    in_ch.byte_value = '0;
    in_ch.last_byte = 1'b0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: special messages and the extremes of the byte values.
    send_message({8'd255});
    send_message({8'd0, 8'd0});
    send_message({8'd200, 8'd3, 8'd255});
    send_message({SPDU_DATA, 8'd0, 8'd1, 8'd0, 8'd77});
    send_message({SPDU_DATA, 8'd0, 8'd1, 8'd5});
    send_message({SPDU_DATA, 8'd0, 8'd1});
    send_message({SPDU_NOT_FIN, 8'd0});
    send_message({SPDU_ABORT, 8'd0});
    send_message({SPDU_CONNECT, 8'd28, PI_CALLING, 8'd16, 8'hFF, 8'h00, 8'h55, 8'hAA,
                  8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
                  8'hFE, 8'hFD, 8'hFB, 8'hF7, PI_REQUIRE, 8'd2, 8'hA5, 8'h5A,
                  PGI_USERDATA, 8'd2, 8'd9, 8'd9});
    send_message({SPDU_ACCEPT, 8'd14, PI_ACCEPT, 8'd6, PI_OPTIONS, 8'd1, 8'hC3,
                  PI_VERSION, 8'd1, 8'd2, PI_CALLED, 8'd0, PGI_USERDATA, 8'd0, 8'd1, 8'd2});
    send_message({SPDU_ACCEPT, 8'd6, PI_ACCEPT, 8'd3, PI_OPTIONS, 8'd1, 8'h11, PGI_USERDATA});
    send_message({SPDU_FINISH, 8'd9, PI_CALLED, 8'd3, 8'd7, 8'd8, 8'd9, PGI_USERDATA, 8'd0});
    send_message({SPDU_DISCONNECT, 8'd5, PI_CALLING, 8'd3, 8'd4, 8'd5, 8'd6});
    send_message({SPDU_CONNECT, 8'd2, PGI_USERDATA, 8'd0, 8'd0});
    send_message({SPDU_CONNECT, 8'd3, PI_CALLING, 8'd17, 8'd1});
    send_message({SPDU_CONNECT, 8'd5, PI_REQUIRE, 8'd3, 8'd1, 8'd2, 8'd3});
    send_message({SPDU_ACCEPT, 8'd7, PI_ACCEPT, 8'd5, PI_OPTIONS, 8'd2, 8'd1, 8'd1, 8'd1});
    send_message({SPDU_ACCEPT, 8'd8, PI_ACCEPT, 8'd6, PI_OPTIONS, 8'd1, 8'd0,
                  PI_VERSION, 8'd1, 8'd3});
    send_message({SPDU_FINISH, 8'd20, 8'd99, 8'd0, 8'd17, 8'd1, 8'd0, 8'd60, 8'd0,
                  PI_CALLED, 8'd9, 8'd1, 8'd2, 8'd3});

    // Random messages, with one stretch without any idling.
    msgs = 0;
    while (bytes_sent < 1800) begin
      calm = (msgs >= 30 && msgs < 60);
      send_message(random_message());
      msgs++;
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("session_spdu_parser: match");
    end else begin
      $display("session_spdu_parser: mismatch");
    end
    $finish;
  end

endmodule
